@@ sv/fsbp_pkg.sv @@
// Shared types and constants for the fixed slot buffer pool.
`timescale 1ns / 1ps

package fsbp_pkg;

   localparam int DEFAULT_MAX_SLOTS = 256;

   localparam int ADDR_W   = 32;
   localparam int BLOCKS_W = 11;
   localparam int COUNT_W  = 9;
   localparam int CMD_W    = 2;
   localparam int STATUS_W = 2;
   localparam int CSR_IDX_W = 2;

   localparam int BLOCK_SHIFT = 6;
   localparam int SIZE_W      = BLOCKS_W + BLOCK_SHIFT;
   localparam int QUOT_W      = ADDR_W - BLOCK_SHIFT;

   localparam logic [CMD_W-1:0] CMD_ALLOC  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_FREE   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_REFILL = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY   = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_BASE_ADDRESS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOT_BLOCKS  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOT_COUNT   = 2'd2;

   localparam logic [ADDR_W-1:0]   RESET_BASE_ADDRESS = '0;
   localparam logic [BLOCKS_W-1:0] RESET_SLOT_BLOCKS  = 11'd1;
   localparam logic [COUNT_W-1:0]  RESET_SLOT_COUNT   = 9'd256;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [ADDR_W-1:0] request_size;
      logic [ADDR_W-1:0] free_address;
   } req_payload_type;

   typedef struct packed {
      logic [ADDR_W-1:0]   slot_address;
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0]  free_slots;
   } rsp_payload_type;

endpackage

@@ sv/fsbp_divider.sv @@
// Iterative restoring divider: one quotient bit per cycle.
`timescale 1ns / 1ps

module fsbp_divider (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [fsbp_pkg::QUOT_W-1:0]         dividend,
   input  logic [fsbp_pkg::BLOCKS_W-1:0]       divisor,
   output logic                                done,
   output logic [fsbp_pkg::QUOT_W-1:0]         quotient
);

   localparam int QW = fsbp_pkg::QUOT_W;
   localparam int DW = fsbp_pkg::BLOCKS_W;
   localparam int CNTW = $clog2(QW + 1);

   logic [QW-1:0]   quot_ff, quot_in;
   logic [DW-1:0]   rem_ff, rem_in;
   logic [DW-1:0]   div_ff, div_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic            done_ff, done_in;
   logic [DW:0]     rem_sh;
   logic            fits;

   always_comb begin
      rem_sh  = {rem_ff, quot_ff[QW-1]};
      fits    = (rem_sh >= {1'b0, div_ff});
      quot_in = quot_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         quot_in = dividend;
         rem_in  = '0;
         div_in  = divisor;
         cnt_in  = CNTW'(QW);
      end else if (cnt_ff != '0) begin
         quot_in = {quot_ff[QW-2:0], fits};
         rem_in  = fits ? DW'(rem_sh - {1'b0, div_ff}) : rem_sh[DW-1:0];
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == CNTW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

@@ sv/fixed_slot_buffer_pool_core.sv @@
// Fixed slot buffer pool: top level with free-index ring and request sequencer.
//
// Requests arrive on req_valid/req_stall/req_data; one result per request
// leaves on rsp_valid/rsp_stall/rsp_data. A transfer happens when valid is
// high and stall is low. Commands: allocate pops the oldest free slot index
// and answers base + index * slot size; free divides the offset from the
// base by the slot size and pushes the slot index; refill restores all
// slots in index order. Every result carries the free slot count.
// One request at a time: req_stall is high from acceptance until the result
// is loaded into the output register. Allocate passes through the ring read,
// multiply and add states; refill and requests rejected at decode answer
// from decode itself; free waits for the bit-serial divider, which produces
// one of 26 quotient bits per cycle, then checks the index and a full pool.
// A finished result waits in the output register while rsp_stall is high;
// the next request may be accepted meanwhile but its result waits for it.
// Reset (synchronous) restores the registers to base 0, one block per slot,
// 256 slots, and clears a fill count so every entry not yet written reads as
// its own index; no clearing pass is needed. Registers are written via
// csr_write; the user must do so only while idle: the block does not enforce it.
`timescale 1ns / 1ps

module fixed_slot_buffer_pool_core #(
   parameter int MAX_SLOTS = fsbp_pkg::DEFAULT_MAX_SLOTS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  fsbp_pkg::req_payload_type           req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output fsbp_pkg::rsp_payload_type           rsp_data,
   input  logic                                csr_write,
   input  logic [fsbp_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [fsbp_pkg::ADDR_W-1:0]         csr_data
);

   localparam int PW = $clog2(MAX_SLOTS);
   localparam int CW = $clog2(MAX_SLOTS + 1);
   localparam int NW = (CW > fsbp_pkg::COUNT_W) ? CW : fsbp_pkg::COUNT_W;
   localparam int AW = NW + 1;
   localparam int AD = fsbp_pkg::ADDR_W;
   localparam int SW = fsbp_pkg::SIZE_W;
   localparam int QW = fsbp_pkg::QUOT_W;
   localparam int BW = fsbp_pkg::BLOCKS_W;
   localparam int RESET_TOTAL =
      (MAX_SLOTS < int'(fsbp_pkg::RESET_SLOT_COUNT)) ? MAX_SLOTS
                                                     : int'(fsbp_pkg::RESET_SLOT_COUNT);

   typedef enum logic [6:0] {
      ST_IDLE      = 7'b0000001,
      ST_DECODE    = 7'b0000010,
      ST_ALLOC_RD  = 7'b0000100,
      ST_ALLOC_MUL = 7'b0001000,
      ST_ALLOC_ADD = 7'b0010000,
      ST_DIV       = 7'b0100000,
      ST_FREE      = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic      resp_pend_ff, resp_pend_in;

   logic [AD-1:0] base_ff;
   logic [BW-1:0] blocks_ff;
   logic [fsbp_pkg::COUNT_W-1:0] count_ff;

   fsbp_pkg::req_payload_type req_ff;

   logic [PW-1:0] ring_mem [MAX_SLOTS];
   logic [PW-1:0] rd_data_ff;
   logic          rd_valid_ff;
   logic [CW-1:0] fill_ff, fill_in;
   logic [PW-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [CW-1:0] total_ff, total_in;

   logic [PW+SW-1:0] prod_ff, prod_in;
   logic [AD-1:0] res_addr_ff, res_addr_in;
   logic [fsbp_pkg::STATUS_W-1:0] res_status_ff, res_status_in;

   logic rsp_valid_ff, rsp_valid_in;
   fsbp_pkg::rsp_payload_type rsp_data_ff, rsp_data_in;

   logic          ring_we;
   logic [NW-1:0] eff_n;
   logic [NW-1:0] count_ext;
   logic [BW-1:0] blocks_eff;
   logic [SW-1:0] slot_size;
   logic [AD-1:0] offset;
   logic [PW-1:0] idx_sel;
   logic [NW-1:0] total_ext;
   logic          out_free;
   logic          accept;
   logic [PW-1:0] rp_next, wp_next;
   logic [AW-1:0] rp_inc, wp_inc;
   logic          div_start;
   logic          div_done;
   logic [QW-1:0] quotient;

   fsbp_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (offset[AD-1:fsbp_pkg::BLOCK_SHIFT]),
      .divisor  (blocks_eff),
      .done     (div_done),
      .quotient (quotient)
   );

   always_comb begin
      count_ext = NW'(count_ff);
      if (count_ext < NW'(2)) begin
         eff_n = NW'(2);
      end else if (count_ext > NW'(MAX_SLOTS)) begin
         eff_n = NW'(MAX_SLOTS);
      end else begin
         eff_n = count_ext;
      end
      blocks_eff = (blocks_ff == '0) ? BW'(1) : blocks_ff;
      slot_size  = {blocks_eff, {fsbp_pkg::BLOCK_SHIFT{1'b0}}};
      offset     = req_ff.free_address - base_ff;
      idx_sel    = rd_valid_ff ? rd_data_ff : rp_ff;
      rp_inc     = AW'(rp_ff) + AW'(1);
      wp_inc     = AW'(wp_ff) + AW'(1);
      rp_next    = (rp_inc >= AW'(eff_n)) ? '0 : rp_inc[PW-1:0];
      wp_next    = (wp_inc >= AW'(eff_n)) ? '0 : wp_inc[PW-1:0];
      total_ext  = NW'(total_ff);
      out_free   = !rsp_valid_ff || !rsp_stall;
      accept     = req_valid && !req_stall;
   end

   always_comb begin
      state_in      = state_ff;
      resp_pend_in  = resp_pend_ff;
      fill_in       = fill_ff;
      wp_in         = wp_ff;
      rp_in         = rp_ff;
      total_in      = total_ff;
      prod_in       = prod_ff;
      res_addr_in   = res_addr_ff;
      res_status_in = res_status_ff;
      ring_we       = 1'b0;
      div_start     = 1'b0;

      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (resp_pend_ff && out_free) begin
         rsp_valid_in             = 1'b1;
         rsp_data_in.slot_address = res_addr_ff;
         rsp_data_in.status       = res_status_ff;
         rsp_data_in.free_slots   = total_ext[fsbp_pkg::COUNT_W-1:0];
         resp_pend_in             = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            res_addr_in   = '0;
            res_status_in = fsbp_pkg::STATUS_OK;
            state_in      = ST_IDLE;
            unique case (req_ff.cmd)
               fsbp_pkg::CMD_ALLOC: begin
                  if (req_ff.request_size > AD'(slot_size)) begin
                     res_status_in = fsbp_pkg::STATUS_INVALID;
                  end else if (total_ff == '0) begin
                     res_status_in = fsbp_pkg::STATUS_EMPTY;
                  end else begin
                     state_in = ST_ALLOC_RD;
                  end
               end
               fsbp_pkg::CMD_FREE: begin
                  if (req_ff.free_address < base_ff) begin
                     res_status_in = fsbp_pkg::STATUS_INVALID;
                  end else begin
                     div_start = 1'b1;
                     state_in  = ST_DIV;
                  end
               end
               fsbp_pkg::CMD_REFILL: begin
                  fill_in  = '0;
                  wp_in    = '0;
                  rp_in    = '0;
                  total_in = CW'(eff_n);
               end
               default: begin
                  res_status_in = fsbp_pkg::STATUS_INVALID;
               end
            endcase
            if (state_in == ST_IDLE) begin
               resp_pend_in = 1'b1;
            end
         end
         ST_ALLOC_RD: begin
            state_in = ST_ALLOC_MUL;
         end
         ST_ALLOC_MUL: begin
            prod_in  = (PW+SW)'(idx_sel) * (PW+SW)'(slot_size);
            state_in = ST_ALLOC_ADD;
         end
         ST_ALLOC_ADD: begin
            res_addr_in  = base_ff + AD'(prod_ff);
            rp_in        = rp_next;
            total_in     = total_ff - 1'b1;
            resp_pend_in = 1'b1;
            state_in     = ST_IDLE;
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_FREE;
            end
         end
         ST_FREE: begin
            if (quotient >= QW'(eff_n)) begin
               res_status_in = fsbp_pkg::STATUS_INVALID;
            end else if (AW'(total_ff) >= AW'(eff_n)) begin
               res_status_in = fsbp_pkg::STATUS_FULL;
            end else begin
               ring_we  = 1'b1;
               if (CW'(wp_ff) >= fill_ff) begin
                  fill_in = CW'(wp_ff) + CW'(1);
               end
               wp_in    = wp_next;
               total_in = total_ff + 1'b1;
            end
            resp_pend_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         resp_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         base_ff      <= fsbp_pkg::RESET_BASE_ADDRESS;
         blocks_ff    <= fsbp_pkg::RESET_SLOT_BLOCKS;
         count_ff     <= fsbp_pkg::RESET_SLOT_COUNT;
         fill_ff      <= '0;
         wp_ff        <= '0;
         rp_ff        <= '0;
         total_ff     <= CW'(RESET_TOTAL);
      end else begin
         state_ff     <= state_in;
         resp_pend_ff <= resp_pend_in;
         rsp_valid_ff <= rsp_valid_in;
         fill_ff      <= fill_in;
         wp_ff        <= wp_in;
         rp_ff        <= rp_in;
         total_ff     <= total_in;
         if (csr_write) begin
            unique case (csr_index)
               fsbp_pkg::CSR_BASE_ADDRESS: base_ff   <= csr_data;
               fsbp_pkg::CSR_SLOT_BLOCKS:  blocks_ff <= csr_data[BW-1:0];
               fsbp_pkg::CSR_SLOT_COUNT:   count_ff  <= csr_data[fsbp_pkg::COUNT_W-1:0];
               default: ;
            endcase
         end
      end
      if (accept) begin
         req_ff <= req_data;
      end
      prod_ff       <= prod_in;
      res_addr_ff   <= res_addr_in;
      res_status_ff <= res_status_in;
      rsp_data_ff   <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring_mem[wp_ff] <= quotient[PW-1:0];
      end
      rd_data_ff  <= ring_mem[rp_ff];
      rd_valid_ff <= (CW'(rp_ff) < fill_ff);
   end

   assign req_stall = (state_ff != ST_IDLE) || resp_pend_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ tb/sv/tb_fixed_slot_buffer_pool_core.sv @@
// Testbench for fixed_slot_buffer_pool_core: directed table plus random phases checked by a predictor.
`timescale 1ns / 1ps

module tb_fixed_slot_buffer_pool_core;

   localparam int POOL_MAX    = fsbp_pkg::DEFAULT_MAX_SLOTS;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int PHASES      = 12;
   localparam int PHASE_ITEMS = 160;
   localparam logic [fsbp_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

   typedef enum logic {ROW_REQ, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type                          kind;
      logic [fsbp_pkg::CSR_IDX_W-1:0]        csr_idx;
      logic [fsbp_pkg::ADDR_W-1:0]           csr_val;
      fsbp_pkg::req_payload_type             req;
      bit                                    typed;
      fsbp_pkg::rsp_payload_type             rsp;
   } dir_row_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_stall;
   fsbp_pkg::req_payload_type       req_data = '0;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   fsbp_pkg::rsp_payload_type       rsp_data;
   logic                            csr_write = 1'b0;
   logic [fsbp_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [fsbp_pkg::ADDR_W-1:0]     csr_data = '0;

   // predictor state
   logic [7:0]                      idx_ring [POOL_MAX];
   int unsigned                     push_ptr;
   int unsigned                     pop_ptr;
   logic [fsbp_pkg::COUNT_W-1:0]    avail;
   logic [fsbp_pkg::ADDR_W-1:0]     reg_base;
   logic [fsbp_pkg::BLOCKS_W-1:0]   reg_blocks;
   logic [fsbp_pkg::COUNT_W-1:0]    reg_count;

   fsbp_pkg::rsp_payload_type       pending_results [$];
   logic [fsbp_pkg::ADDR_W-1:0]     live_addrs [$];
   dir_row_type                     directed_rows [$];
   fsbp_pkg::rsp_payload_type       want_rsp;
   int                              mismatches = 0;
   int                              cycle_count = 0;
   bit                              idle_enable = 1'b1;

   fixed_slot_buffer_pool_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int unsigned pool_slots();
      if (reg_count < 2) return 2;
      if (reg_count > POOL_MAX) return POOL_MAX;
      return reg_count;
   endfunction

   function automatic logic [fsbp_pkg::ADDR_W-1:0] slot_size();
      if (reg_blocks == '0) return 32'd64;
      return {{(fsbp_pkg::ADDR_W-fsbp_pkg::SIZE_W){1'b0}}, reg_blocks,
              {fsbp_pkg::BLOCK_SHIFT{1'b0}}};
   endfunction

   function automatic void restock_ring();
      int unsigned n;
      for (int i = 0; i < POOL_MAX; i++) idx_ring[i] = i[7:0];
      push_ptr = 0;
      pop_ptr  = 0;
      n        = pool_slots();
      avail    = n[fsbp_pkg::COUNT_W-1:0];
   endfunction

   function automatic fsbp_pkg::rsp_payload_type pool_step(input fsbp_pkg::req_payload_type r);
      fsbp_pkg::rsp_payload_type   res;
      int unsigned                 n;
      logic [fsbp_pkg::ADDR_W-1:0] sz;
      logic [fsbp_pkg::ADDR_W-1:0] idx;
      n = pool_slots();
      sz = slot_size();
      res = '0;
      res.status = fsbp_pkg::STATUS_OK;
      case (r.cmd)
         fsbp_pkg::CMD_ALLOC: begin
            if (r.request_size > sz) res.status = fsbp_pkg::STATUS_INVALID;
            else if (avail == '0) res.status = fsbp_pkg::STATUS_EMPTY;
            else begin
               res.slot_address = reg_base + idx_ring[pop_ptr % POOL_MAX] * sz;
               avail = avail - 1'b1;
               pop_ptr = (pop_ptr + 1 >= n) ? 0 : pop_ptr + 1;
            end
         end
         fsbp_pkg::CMD_FREE: begin
            if (r.free_address < reg_base) res.status = fsbp_pkg::STATUS_INVALID;
            else begin
               idx = (r.free_address - reg_base) / sz;
               if (idx >= n) res.status = fsbp_pkg::STATUS_INVALID;
               else if (avail >= n) res.status = fsbp_pkg::STATUS_FULL;
               else begin
                  idx_ring[push_ptr % POOL_MAX] = idx[7:0];
                  avail = avail + 1'b1;
                  push_ptr = (push_ptr + 1 >= n) ? 0 : push_ptr + 1;
               end
            end
         end
         fsbp_pkg::CMD_REFILL: restock_ring();
         default: res.status = fsbp_pkg::STATUS_INVALID;
      endcase
      res.free_slots = avail;
      return res;
   endfunction

   function automatic dir_row_type req_row(input logic [fsbp_pkg::CMD_W-1:0] cmd,
                                           input logic [fsbp_pkg::ADDR_W-1:0] size,
                                           input logic [fsbp_pkg::ADDR_W-1:0] addr);
      dir_row_type row;
      row.kind = ROW_REQ;
      row.csr_idx = '0;
      row.csr_val = '0;
      row.req = '0;
      row.typed = 1'b0;
      row.rsp = '0;
      row.req.cmd = cmd;
      row.req.request_size = size;
      row.req.free_address = addr;
      return row;
   endfunction

   function automatic dir_row_type chk_row(input logic [fsbp_pkg::CMD_W-1:0] cmd,
                                           input logic [fsbp_pkg::ADDR_W-1:0] size,
                                           input logic [fsbp_pkg::ADDR_W-1:0] addr,
                                           input logic [fsbp_pkg::ADDR_W-1:0] e_addr,
                                           input logic [fsbp_pkg::STATUS_W-1:0] e_status,
                                           input logic [fsbp_pkg::COUNT_W-1:0] e_free);
      dir_row_type row;
      row = req_row(cmd, size, addr);
      row.typed = 1'b1;
      row.rsp.slot_address = e_addr;
      row.rsp.status = e_status;
      row.rsp.free_slots = e_free;
      return row;
   endfunction

   function automatic dir_row_type csr_row(input logic [fsbp_pkg::CSR_IDX_W-1:0] idx,
                                           input logic [fsbp_pkg::ADDR_W-1:0] val);
      dir_row_type row;
      row.kind = ROW_CSR;
      row.csr_idx = idx;
      row.csr_val = val;
      row.req = '0;
      row.typed = 1'b0;
      row.rsp = '0;
      return row;
   endfunction

   // offer one request, predict it on transfer
   task automatic send_item(input fsbp_pkg::req_payload_type item, input bit typed,
                            input fsbp_pkg::rsp_payload_type typed_rsp);
      fsbp_pkg::rsp_payload_type res;
      while (idle_enable && $urandom_range(99) < 30) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      res = pool_step(item);
      pending_results.push_back(typed ? typed_rsp : res);
      if (item.cmd == fsbp_pkg::CMD_ALLOC && res.status == fsbp_pkg::STATUS_OK)
         live_addrs.push_back(res.slot_address);
      if (item.cmd == fsbp_pkg::CMD_REFILL) live_addrs.delete();
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   task automatic write_reg(input logic [fsbp_pkg::CSR_IDX_W-1:0] idx,
                            input logic [fsbp_pkg::ADDR_W-1:0] val);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      csr_write <= 1'b0;
      case (idx)
         fsbp_pkg::CSR_BASE_ADDRESS: reg_base = val;
         fsbp_pkg::CSR_SLOT_BLOCKS:  reg_blocks = val[fsbp_pkg::BLOCKS_W-1:0];
         fsbp_pkg::CSR_SLOT_COUNT:   reg_count = val[fsbp_pkg::COUNT_W-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic random_request(output fsbp_pkg::req_payload_type r);
      int unsigned                 roll;
      int unsigned                 sel;
      int unsigned                 k;
      int unsigned                 n;
      logic [fsbp_pkg::ADDR_W-1:0] sz;
      n = pool_slots();
      sz = slot_size();
      roll = $urandom_range(99);
      sel = $urandom_range(9);
      r.request_size = $urandom;
      r.free_address = $urandom;
      if (roll < 50) begin
         r.cmd = fsbp_pkg::CMD_ALLOC;
         if (sel < 7) r.request_size = $urandom_range(sz);
         else if (sel == 7) r.request_size = sz;
         else if (sel == 8) r.request_size = sz + 1;
      end else if (roll < 94) begin
         r.cmd = fsbp_pkg::CMD_FREE;
         if (sel < 7 && live_addrs.size() != 0) begin
            k = $urandom_range(live_addrs.size() - 1);
            r.free_address = live_addrs[k] + $urandom_range(sz - 1);
            // sel 0 keeps the address around for a later double free
            if (sel != 0) live_addrs.delete(k);
         end else if (sel < 7) r.free_address = reg_base + $urandom_range(n - 1) * sz;
         else if (sel == 7) r.free_address = reg_base + n * sz;
         else if (sel == 8) r.free_address = reg_base - 1;
      end else if (roll < 97) r.cmd = fsbp_pkg::CMD_REFILL;
      else r.cmd = CMD_UNUSED;
   endtask

   always @(posedge clock) rsp_stall <= idle_enable && ($urandom_range(99) < 30);

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $error("result with none expected: %p", rsp_data);
            mismatches++;
         end else begin
            want_rsp = pending_results.pop_front();
            if (rsp_data.slot_address !== want_rsp.slot_address) begin
               $error("slot_address: expected %h, got %h",
                      want_rsp.slot_address, rsp_data.slot_address);
               mismatches++;
            end
            if (rsp_data.status !== want_rsp.status) begin
               $error("status: expected %0d, got %0d", want_rsp.status, rsp_data.status);
               mismatches++;
            end
            if (rsp_data.free_slots !== want_rsp.free_slots) begin
               $error("free_slots: expected %0d, got %0d",
                      want_rsp.free_slots, rsp_data.free_slots);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("** fixed_slot_buffer_pool_core: FAILED **");
         $finish;
      end
   end

   initial begin
      fsbp_pkg::req_payload_type   item;
      logic [fsbp_pkg::ADDR_W-1:0] base_val;
      logic [fsbp_pkg::ADDR_W-1:0] blocks_val;
      logic [fsbp_pkg::ADDR_W-1:0] count_val;

      reg_base = fsbp_pkg::RESET_BASE_ADDRESS;
      reg_blocks = fsbp_pkg::RESET_SLOT_BLOCKS;
      reg_count = fsbp_pkg::RESET_SLOT_COUNT;
      restock_ring();

      // reset config: base 0, 64-byte slots, 256 slots
      directed_rows.push_back(chk_row(fsbp_pkg::CMD_ALLOC, 32'd0, 32'h0123_4567, 32'd0,
                                      fsbp_pkg::STATUS_OK, 9'd255));
      directed_rows.push_back(chk_row(fsbp_pkg::CMD_ALLOC, 32'd64, 32'd0, 32'd64,
                                      fsbp_pkg::STATUS_OK, 9'd254));
      directed_rows.push_back(chk_row(fsbp_pkg::CMD_ALLOC, 32'd65, 32'd0, 32'd0,
                                      fsbp_pkg::STATUS_INVALID, 9'd254));
      directed_rows.push_back(chk_row(fsbp_pkg::CMD_ALLOC, 32'hFFFF_FFFF, 32'd0, 32'd0,
                                      fsbp_pkg::STATUS_INVALID, 9'd254));
      directed_rows.push_back(chk_row(fsbp_pkg::CMD_FREE, 32'd0, 32'h7F, 32'd0,
                                      fsbp_pkg::STATUS_OK, 9'd255));
      directed_rows.push_back(chk_row(fsbp_pkg::CMD_FREE, 32'd0, 32'h0, 32'd0,
                                      fsbp_pkg::STATUS_OK, 9'd256));
      directed_rows.push_back(chk_row(fsbp_pkg::CMD_FREE, 32'd0, 32'h0, 32'd0,
                                      fsbp_pkg::STATUS_FULL, 9'd256));
      directed_rows.push_back(chk_row(fsbp_pkg::CMD_FREE, 32'd0, 32'h4000, 32'd0,
                                      fsbp_pkg::STATUS_INVALID, 9'd256));
      directed_rows.push_back(chk_row(fsbp_pkg::CMD_FREE, 32'd0, 32'hFFFF_FFFF, 32'd0,
                                      fsbp_pkg::STATUS_INVALID, 9'd256));
      directed_rows.push_back(chk_row(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0,
                                      fsbp_pkg::STATUS_INVALID, 9'd256));
      directed_rows.push_back(chk_row(fsbp_pkg::CMD_REFILL, 32'd0, 32'd0, 32'd0,
                                      fsbp_pkg::STATUS_OK, 9'd256));
      directed_rows.push_back(chk_row(fsbp_pkg::CMD_ALLOC, 32'd1, 32'd0, 32'd0,
                                      fsbp_pkg::STATUS_OK, 9'd255));
      // two slots near the top of memory: empty pool, address below base
      directed_rows.push_back(csr_row(fsbp_pkg::CSR_BASE_ADDRESS, 32'hFFFF_FF80));
      directed_rows.push_back(csr_row(fsbp_pkg::CSR_SLOT_COUNT, 32'd2));
      directed_rows.push_back(chk_row(fsbp_pkg::CMD_REFILL, 32'd0, 32'd0, 32'd0,
                                      fsbp_pkg::STATUS_OK, 9'd2));
      directed_rows.push_back(chk_row(fsbp_pkg::CMD_ALLOC, 32'd0, 32'd0, 32'hFFFF_FF80,
                                      fsbp_pkg::STATUS_OK, 9'd1));
      directed_rows.push_back(chk_row(fsbp_pkg::CMD_ALLOC, 32'd64, 32'd0, 32'hFFFF_FFC0,
                                      fsbp_pkg::STATUS_OK, 9'd0));
      directed_rows.push_back(chk_row(fsbp_pkg::CMD_ALLOC, 32'd1, 32'd0, 32'd0,
                                      fsbp_pkg::STATUS_EMPTY, 9'd0));
      directed_rows.push_back(chk_row(fsbp_pkg::CMD_FREE, 32'd0, 32'h10, 32'd0,
                                      fsbp_pkg::STATUS_INVALID, 9'd0));
      directed_rows.push_back(chk_row(fsbp_pkg::CMD_FREE, 32'd0, 32'hFFFF_FFFF, 32'd0,
                                      fsbp_pkg::STATUS_OK, 9'd1));
      // zero slot size and zero count fall back to their minimums
      directed_rows.push_back(csr_row(fsbp_pkg::CSR_BASE_ADDRESS, 32'd0));
      directed_rows.push_back(csr_row(fsbp_pkg::CSR_SLOT_BLOCKS, 32'd0));
      directed_rows.push_back(csr_row(fsbp_pkg::CSR_SLOT_COUNT, 32'd0));
      directed_rows.push_back(req_row(fsbp_pkg::CMD_FREE, 32'd0, 32'h40));
      directed_rows.push_back(req_row(fsbp_pkg::CMD_ALLOC, 32'd64, 32'd0));
      // widest slot, count above the maximum
      directed_rows.push_back(csr_row(fsbp_pkg::CSR_SLOT_BLOCKS, 32'd2047));
      directed_rows.push_back(csr_row(fsbp_pkg::CSR_SLOT_COUNT, 32'd511));
      directed_rows.push_back(chk_row(fsbp_pkg::CMD_REFILL, 32'd0, 32'd0, 32'd0,
                                      fsbp_pkg::STATUS_OK, 9'd256));
      directed_rows.push_back(chk_row(fsbp_pkg::CMD_ALLOC, 32'd131008, 32'd0, 32'd0,
                                      fsbp_pkg::STATUS_OK, 9'd255));
      directed_rows.push_back(chk_row(fsbp_pkg::CMD_ALLOC, 32'd131009, 32'd0, 32'd0,
                                      fsbp_pkg::STATUS_INVALID, 9'd255));
      directed_rows.push_back(req_row(fsbp_pkg::CMD_FREE, 32'd0, 32'd131008 * 255 + 5));

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CSR)
            write_reg(directed_rows[i].csr_idx, directed_rows[i].csr_val);
         else
            send_item(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].rsp);
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin base_val = 32'd0;         blocks_val = 32'd1;    count_val = 32'd2;   end
            1: begin base_val = 32'hFFFF_FFFF; blocks_val = 32'd1024; count_val = 32'd256; end
            2: begin base_val = 32'hFFFF_0000; blocks_val = 32'd2047; count_val = 32'd511; end
            3: begin base_val = $urandom;      blocks_val = 32'd0;    count_val = 32'd1;   end
            default: begin
               base_val = ($urandom_range(2) == 0) ? 32'd0 : $urandom;
               blocks_val = $urandom_range(1, 8);
               count_val = ($urandom_range(3) == 0) ? $urandom_range(0, 511)
                                                    : $urandom_range(2, 24);
            end
         endcase
         write_reg(fsbp_pkg::CSR_BASE_ADDRESS, base_val);
         write_reg(fsbp_pkg::CSR_SLOT_BLOCKS, blocks_val);
         write_reg(fsbp_pkg::CSR_SLOT_COUNT, count_val);
         idle_enable = (phase != 5);
         // every fourth phase keeps the old ring across the count change
         if (phase % 4 != 3) begin
            item.cmd = fsbp_pkg::CMD_REFILL;
            item.request_size = $urandom;
            item.free_address = $urandom;
            send_item(item, 1'b0, '0);
         end
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if (phase == 7 && k == PHASE_ITEMS / 2) drain();
            random_request(item);
            send_item(item, 1'b0, '0);
         end
      end

      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (mismatches == 0)
         $display("** fixed_slot_buffer_pool_core: PASSED **");
      else
         $display("** fixed_slot_buffer_pool_core: FAILED **");
      $finish;
   end

endmodule

@@ files.f @@
sv/fsbp_pkg.sv
sv/fsbp_divider.sv
sv/fixed_slot_buffer_pool_core.sv
tb/sv/tb_fixed_slot_buffer_pool_core.sv
